>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/srht_pkg.sv
package srht_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int COORD_BITS   = 12;
    localparam int TAB_BITS     = 8;
    localparam int OUT_IDX_BITS = 6;
    localparam int IDX_BITS     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_BITS     = $clog2(MAX_ENTRIES + 1);
    localparam int AREA_BITS    = 2 * COORD_BITS;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [TAB_BITS-1:0]   tab;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } entry_t;

    typedef struct packed {
        logic   is_query;
        entry_t rect;
    } cmd_t;

    localparam int ENTRY_BITS = $bits(entry_t);

endpackage

>>> rtl/core/smallest_rect_hit_test_unit.sv
// Channel   Handshake            Payload
// request   in_valid/in_ready    mode, tab_id, pos_x, pos_y, rect_width, rect_height
// result    out_valid/out_ready  found, entry_index, table_full
//
// An add request completes in the back end as soon as it leaves the two-entry queue.
// A query request scans the stored entries, one entry per cycle, through the single
// read port of the rectangle store, then registers its result.
// Reset clears the entry count and all control state; the store itself is not cleared.
// While a result waits for out_ready, the queue accepts requests until it is full.
module smallest_rect_hit_test_unit import srht_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    mode,
    input  logic [TAB_BITS-1:0]     tab_id,
    input  logic [COORD_BITS-1:0]   pos_x,
    input  logic [COORD_BITS-1:0]   pos_y,
    input  logic [COORD_BITS-1:0]   rect_width,
    input  logic [COORD_BITS-1:0]   rect_height,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    found,
    output logic [OUT_IDX_BITS-1:0] entry_index,
    output logic                    table_full
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    srht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .tab_id     (tab_id),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .rect_width (rect_width),
        .rect_height(rect_height),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    srht_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .entry_index(entry_index),
        .table_full (table_full)
    );

endmodule

>>> rtl/core/srht_ram.sv
module srht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic                                           re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/srht_front.sv
`include "assert_macros.svh"

module srht_front import srht_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [TAB_BITS-1:0]   tab_id,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [COORD_BITS-1:0] rect_width,
    input  logic [COORD_BITS-1:0] rect_height,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output cmd_t                  cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.is_query = (mode == MODE_QUERY);
        cmd_in.rect.tab = tab_id;
        cmd_in.rect.x   = pos_x;
        cmd_in.rect.y   = pos_y;
        cmd_in.rect.w   = rect_width;
        cmd_in.rect.h   = rect_height;
    end

    assign in_ready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    `ASSERT_ALWAYS(a_fill_range, clk, rst_n, fill_reg != 2'd3)
    `ASSERT_NEXT(a_push_visible, clk, rst_n, push, cmd_valid)
    `ASSERT_IMPLIES(a_ptr_match, clk, rst_n, fill_reg != 2'd1, wr_ptr_reg == rd_ptr_reg)

endmodule

>>> rtl/core/srht_back.sv
`include "assert_macros.svh"

module srht_back import srht_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  cmd_t                    cmd,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    found,
    output logic [OUT_IDX_BITS-1:0] entry_index,
    output logic                    table_full
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                    state_reg;
    logic                    state_next;
    logic [CNT_BITS-1:0]     count_reg;
    logic [CNT_BITS-1:0]     count_next;
    logic [CNT_BITS-1:0]     issue_reg;
    logic [CNT_BITS-1:0]     issue_next;
    entry_t                  query_reg;
    entry_t                  query_next;

    logic                    s1_valid_reg;
    logic [IDX_BITS-1:0]     s1_idx_reg;
    logic                    s2_valid_reg;
    logic                    s2_hit_reg;
    logic [IDX_BITS-1:0]     s2_idx_reg;
    logic [AREA_BITS-1:0]    s2_area_reg;

    logic                    best_have_reg;
    logic                    best_have_next;
    logic [IDX_BITS-1:0]     best_idx_reg;
    logic [IDX_BITS-1:0]     best_idx_next;
    logic [AREA_BITS-1:0]    min_area_reg;
    logic [AREA_BITS-1:0]    min_area_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    found_reg;
    logic                    found_next;
    logic [OUT_IDX_BITS-1:0] entry_index_reg;
    logic [OUT_IDX_BITS-1:0] entry_index_next;
    logic                    table_full_reg;
    logic                    table_full_next;

    logic                    pop;
    logic                    is_full;
    logic                    ram_we;
    logic                    rd_en;
    logic                    scan_done;
    entry_t                  rd_entry;
    logic [ENTRY_BITS-1:0]   rd_data;
    logic [COORD_BITS:0]     x_end;
    logic [COORD_BITS:0]     y_end;
    logic                    hit;

    assign cmd_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign pop       = cmd_valid && cmd_ready;
    assign is_full   = (count_reg == CNT_BITS'(MAX_ENTRIES));
    assign ram_we    = pop && !cmd.is_query && !is_full;
    assign rd_en     = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign scan_done = (state_reg == ST_SCAN) && !rd_en && !s1_valid_reg && !s2_valid_reg;

    srht_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(MAX_ENTRIES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[IDX_BITS-1:0]),
        .wdata(cmd.rect),
        .re   (rd_en),
        .raddr(issue_reg[IDX_BITS-1:0]),
        .rdata(rd_data)
    );

    assign rd_entry = entry_t'(rd_data);
    assign x_end    = {1'b0, rd_entry.x} + {1'b0, rd_entry.w};
    assign y_end    = {1'b0, rd_entry.y} + {1'b0, rd_entry.h};
    assign hit      = (rd_entry.tab == query_reg.tab)
                   && (rd_entry.x <= query_reg.x)
                   && (rd_entry.y <= query_reg.y)
                   && (x_end >= {1'b0, query_reg.x})
                   && (y_end >= {1'b0, query_reg.y});

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        issue_next       = issue_reg;
        query_next       = query_reg;
        best_have_next   = best_have_reg;
        best_idx_next    = best_idx_reg;
        min_area_next    = min_area_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        found_next       = found_reg;
        entry_index_next = entry_index_reg;
        table_full_next  = table_full_reg;

        if (pop)
        begin
            if (cmd.is_query)
            begin
                state_next     = ST_SCAN;
                query_next     = cmd.rect;
                issue_next     = '0;
                best_have_next = 1'b0;
            end
            else if (is_full)
            begin
                out_valid_next   = 1'b1;
                found_next       = 1'b0;
                entry_index_next = '0;
                table_full_next  = 1'b1;
            end
            else
            begin
                out_valid_next   = 1'b1;
                found_next       = 1'b1;
                entry_index_next = OUT_IDX_BITS'(count_reg);
                table_full_next  = 1'b0;
                count_next       = count_reg + CNT_BITS'(1);
            end
        end

        if (rd_en)
        begin
            issue_next = issue_reg + CNT_BITS'(1);
        end

        if (s2_valid_reg && s2_hit_reg && (!best_have_reg || (s2_area_reg < min_area_reg)))
        begin
            best_have_next = 1'b1;
            best_idx_next  = s2_idx_reg;
            min_area_next  = s2_area_reg;
        end

        if (scan_done)
        begin
            state_next       = ST_IDLE;
            out_valid_next   = 1'b1;
            found_next       = best_have_reg;
            entry_index_next = best_have_reg ? OUT_IDX_BITS'(best_idx_reg) : '0;
            table_full_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            best_have_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            s1_valid_reg  <= rd_en;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
            best_have_reg <= best_have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg       <= issue_next;
        query_reg       <= query_next;
        s1_idx_reg      <= issue_reg[IDX_BITS-1:0];
        s2_idx_reg      <= s1_idx_reg;
        s2_hit_reg      <= hit;
        s2_area_reg     <= AREA_BITS'(rd_entry.w) * AREA_BITS'(rd_entry.h);
        best_idx_reg    <= best_idx_next;
        min_area_reg    <= min_area_next;
        found_reg       <= found_next;
        entry_index_reg <= entry_index_next;
        table_full_reg  <= table_full_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign entry_index = entry_index_reg;
    assign table_full  = table_full_reg;

    `ASSERT_ALWAYS(a_count_max, clk, rst_n, count_reg <= CNT_BITS'(MAX_ENTRIES))
    `ASSERT_IMPLIES(a_scan_no_result, clk, rst_n, state_reg == ST_SCAN, !out_valid_reg)
    `ASSERT_IMPLIES(a_pipe_in_scan, clk, rst_n, s1_valid_reg || s2_valid_reg, state_reg == ST_SCAN)

endmodule

>>> verif/hit_test_checker.sv
module hit_test_checker
    import srht_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    mode,
    input  logic [TAB_BITS-1:0]     tab_id,
    input  logic [COORD_BITS-1:0]   pos_x,
    input  logic [COORD_BITS-1:0]   pos_y,
    input  logic [COORD_BITS-1:0]   rect_width,
    input  logic [COORD_BITS-1:0]   rect_height,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic                    found,
    input  logic [OUT_IDX_BITS-1:0] entry_index,
    input  logic                    table_full,
    output int                      error_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                    found;
        logic [OUT_IDX_BITS-1:0] index;
        logic                    full;
    } hit_result_t;

    entry_t      rect_table [MAX_ENTRIES];
    int          rect_count;
    hit_result_t expected_hits [$];

    // Applies one request to the local copy of the table and returns its result.
    function automatic hit_result_t predict_hit_result(logic op, entry_t req);
        hit_result_t          res;
        entry_t               r;
        logic                 have;
        logic [AREA_BITS-1:0] area;
        logic [AREA_BITS-1:0] min_area;
        int                   i;
        res = '0;
        have = 1'b0;
        min_area = '0;
        if (op == MODE_ADD)
        begin
            if (rect_count >= MAX_ENTRIES)
            begin
                res.full = 1'b1;
            end
            else
            begin
                rect_table[rect_count] = req;
                res.found = 1'b1;
                res.index = OUT_IDX_BITS'(rect_count);
                rect_count++;
            end
        end
        else
        begin
            for (i = 0; i < rect_count; i++)
            begin
                r = rect_table[i];
                if (r.tab == req.tab && r.x <= req.x && r.y <= req.y
                        && {1'b0, r.x} + r.w >= {1'b0, req.x}
                        && {1'b0, r.y} + r.h >= {1'b0, req.y})
                begin
                    area = AREA_BITS'(r.w) * AREA_BITS'(r.h);
                    if (!have || area < min_area)
                    begin
                        have = 1'b1;
                        min_area = area;
                        res.found = 1'b1;
                        res.index = OUT_IDX_BITS'(i);
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        hit_result_t got;
        hit_result_t want;
        entry_t      req;
        if (!rst_n)
        begin
            rect_count = 0;
            expected_hits.delete();
            error_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                req = '{tab: tab_id, x: pos_x, y: pos_y, w: rect_width, h: rect_height};
                expected_hits.push_back(predict_hit_result(mode, req));
            end
            if (out_valid && out_ready)
            begin
                got = '{found: found, index: entry_index, full: table_full};
                if (expected_hits.size() == 0)
                begin
                    log_error($sformatf("unexpected result found=%0b idx=%0d full=%0b",
                                        got.found, got.index, got.full));
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (got.found !== want.found || got.index !== want.index
                            || got.full !== want.full)
                    begin
                        log_error($sformatf(
                            "expected found=%0b idx=%0d full=%0b, got found=%0b idx=%0d full=%0b",
                            want.found, want.index, want.full,
                            got.found, got.index, got.full));
                    end
                end
            end
        end
        pending = expected_hits.size();
    end

endmodule

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srht_pkg::*;

    localparam int IDLE_PERCENT    = 22;
    localparam int RANDOM_REQUESTS = 1280;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 100;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    mode = MODE_ADD;
    logic [TAB_BITS-1:0]     tab_id = '0;
    logic [COORD_BITS-1:0]   pos_x = '0;
    logic [COORD_BITS-1:0]   pos_y = '0;
    logic [COORD_BITS-1:0]   rect_width = '0;
    logic [COORD_BITS-1:0]   rect_height = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    found;
    logic [OUT_IDX_BITS-1:0] entry_index;
    logic                    table_full;

    int     errors;
    int     pending;
    int     stall_cycles = 0;
    logic   quiet = 1'b0;
    logic   hold_request = 1'b0;
    entry_t placed [MAX_ENTRIES];
    int     placed_count = 0;

    always #1 clk = ~clk;

    smallest_rect_hit_test_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .tab_id      (tab_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .entry_index (entry_index),
        .table_full  (table_full)
    );

    hit_test_checker hit_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .tab_id      (tab_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .entry_index (entry_index),
        .table_full  (table_full),
        .error_count (errors),
        .pending     (pending)
    );

    function automatic logic [TAB_BITS-1:0] rand_tab();
        if ($urandom_range(0, 99) < 80)
        begin
            return TAB_BITS'($urandom_range(0, 3));
        end
        return TAB_BITS'($urandom);
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            return COORD_BITS'($urandom_range(0, 15));
        end
        if (pick < 60)
        begin
            return COORD_BITS'($urandom_range(16, 600));
        end
        if (pick < 85)
        begin
            return COORD_BITS'($urandom_range(600, 4095));
        end
        return COORD_BITS'($urandom);
    endfunction

    task automatic send_request(input logic op, input logic [TAB_BITS-1:0] tab,
                                input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                                input logic [COORD_BITS-1:0] pw, input logic [COORD_BITS-1:0] ph);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        tab_id      <= tab;
        pos_x       <= px;
        pos_y       <= py;
        rect_width  <= pw;
        rect_height <= ph;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == MODE_ADD && placed_count < MAX_ENTRIES)
        begin
            placed[placed_count] = '{tab: tab, x: px, y: py, w: pw, h: ph};
            placed_count++;
        end
    endtask

    // The receiver holds off for a long stretch when asked, otherwise stalls at random while quiet is clear.
    initial
    begin : receiver
        int hold_count;
        hold_count = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_count == 0)
            begin
                hold_count = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : stimulus
        entry_t r;
        int     pick;
        int     n;
        logic   do_add;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then extremes, ties, degenerate rectangles and tab mismatches.
        send_request(MODE_QUERY, 8'd0,   12'd0,    12'd0,    12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd255, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_request(MODE_ADD,   8'd0,   12'd0,    12'd0,    12'd4095, 12'd4095);
        send_request(MODE_ADD,   8'd0,   12'd100,  12'd100,  12'd50,   12'd40);
        send_request(MODE_ADD,   8'd0,   12'd100,  12'd100,  12'd40,   12'd50);
        send_request(MODE_ADD,   8'd0,   12'd120,  12'd110,  12'd0,    12'd30);
        send_request(MODE_ADD,   8'd255, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_request(MODE_ADD,   8'd5,   12'd2000, 12'd3000, 12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd0,   12'd110,  12'd110,  12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd0,   12'd100,  12'd100,  12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd0,   12'd150,  12'd140,  12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd0,   12'd120,  12'd125,  12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd0,   12'd121,  12'd125,  12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd0,   12'd4095, 12'd4095, 12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd255, 12'd4095, 12'd4095, 12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd255, 12'd4094, 12'd4095, 12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd5,   12'd2000, 12'd3000, 12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd5,   12'd2001, 12'd3000, 12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd1,   12'd110,  12'd110,  12'd0,    12'd0);
        send_request(MODE_QUERY, 8'd0,   12'd110,  12'd110,  12'd4095, 12'd4095);
        send_request(MODE_ADD,   8'd0,   12'd4095, 12'd0,    12'd0,    12'd4095);
        send_request(MODE_QUERY, 8'd0,   12'd4095, 12'd2000, 12'd0,    12'd0);

        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            quiet = (n >= 400 && n < 600);
            if (n == 700)
            begin
                hold_request = 1'b1;
            end
            if (n == 1000)
            begin
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending != 0);
                @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            do_add = (placed_count < MAX_ENTRIES) ? ($urandom_range(0, 99) < 45)
                                                  : ($urandom_range(0, 99) < 6);
            if (do_add)
            begin
                if (placed_count > 0 && pick < 50)
                begin
                    r = placed[$urandom_range(0, placed_count - 1)];
                    if (pick >= 10)
                    begin
                        r.x = r.x + COORD_BITS'($urandom_range(0, r.w));
                        r.y = r.y + COORD_BITS'($urandom_range(0, r.h));
                        r.w = COORD_BITS'($urandom_range(0, r.w));
                        r.h = COORD_BITS'($urandom_range(0, r.h));
                    end
                end
                else
                begin
                    r.tab = rand_tab();
                    r.x = COORD_BITS'($urandom);
                    r.y = COORD_BITS'($urandom);
                    r.w = rand_span();
                    r.h = rand_span();
                end
                send_request(MODE_ADD, r.tab, r.x, r.y, r.w, r.h);
            end
            else
            begin
                if (placed_count > 0 && pick < 75)
                begin
                    r = placed[$urandom_range(0, placed_count - 1)];
                    if (pick < 12)
                    begin
                        r.x = r.x + ($urandom_range(0, 1) ? r.w : '0);
                        r.y = r.y + ($urandom_range(0, 1) ? r.h : '0);
                    end
                    else if (pick < 20)
                    begin
                        r.x = r.x + r.w + COORD_BITS'($urandom_range(0, 1));
                        r.y = r.y + r.h + COORD_BITS'($urandom_range(0, 1));
                    end
                    else
                    begin
                        r.x = r.x + COORD_BITS'($urandom_range(0, r.w));
                        r.y = r.y + COORD_BITS'($urandom_range(0, r.h));
                    end
                end
                else
                begin
                    r.tab = rand_tab();
                    r.x = COORD_BITS'($urandom);
                    r.y = COORD_BITS'($urandom);
                end
                send_request(MODE_QUERY, r.tab, r.x, r.y,
                             COORD_BITS'($urandom), COORD_BITS'($urandom));
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/srht_pkg.sv
rtl/core/srht_ram.sv
rtl/core/srht_front.sv
rtl/core/srht_back.sv
rtl/core/smallest_rect_hit_test_unit.sv
verif/hit_test_checker.sv
verif/testbench.sv
